### sv/hry_pkg.sv
// Package: fixed-point widths, matrix coefficients and payload types for the hue rotator.
package hry_pkg;

  localparam int COEF_FRAC_BITS = 14;
  localparam int CHANNEL_BITS   = 8;
  localparam int ANGLE_W        = 16;

  localparam int COEF_W = COEF_FRAC_BITS + 2;
  localparam int YIQ_W  = CHANNEL_BITS + COEF_FRAC_BITS + 2;
  localparam int PROD_W = YIQ_W + ANGLE_W;
  localparam int ROT_W  = PROD_W + 1 - COEF_FRAC_BITS;
  localparam int ACC_W  = ROT_W + COEF_W + 2;

  localparam logic [CHANNEL_BITS-1:0] CHAN_MAX = {CHANNEL_BITS{1'b1}};

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_COS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIN = 2'd1;

  localparam logic signed [ANGLE_W-1:0] COS_RESET = ANGLE_W'(64'sd1 <<< COEF_FRAC_BITS);
  localparam logic signed [ANGLE_W-1:0] SIN_RESET = '0;

  typedef logic signed [COEF_W-1:0] coef_t;

  // round half away from zero, thousandths to F fractional bits
  function automatic longint milli_to_fixed(longint k);
    longint mag;
    longint r;
    mag = (k < 0) ? -k : k;
    r   = (mag * (64'sd1 <<< COEF_FRAC_BITS) * 2 + 1000) / 2000;
    return (k < 0) ? -r : r;
  endfunction

  localparam coef_t TO_YIQ [3][3] = '{
    '{COEF_W'(milli_to_fixed(299)),  COEF_W'(milli_to_fixed(587)),
      COEF_W'(milli_to_fixed(114))},
    '{COEF_W'(milli_to_fixed(596)),  COEF_W'(milli_to_fixed(-274)),
      COEF_W'(milli_to_fixed(-321))},
    '{COEF_W'(milli_to_fixed(211)),  COEF_W'(milli_to_fixed(-523)),
      COEF_W'(milli_to_fixed(311))}
  };

  localparam coef_t TO_RGB [3][3] = '{
    '{COEF_W'(milli_to_fixed(1000)), COEF_W'(milli_to_fixed(956)),
      COEF_W'(milli_to_fixed(621))},
    '{COEF_W'(milli_to_fixed(1000)), COEF_W'(milli_to_fixed(-272)),
      COEF_W'(milli_to_fixed(-647))},
    '{COEF_W'(milli_to_fixed(1000)), COEF_W'(milli_to_fixed(-1107)),
      COEF_W'(milli_to_fixed(1705))}
  };

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red_in;
    logic [CHANNEL_BITS-1:0] green_in;
    logic [CHANNEL_BITS-1:0] blue_in;
    logic                    last_pixel;
  } pix_in_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red_out;
    logic [CHANNEL_BITS-1:0] green_out;
    logic [CHANNEL_BITS-1:0] blue_out;
    logic                    last_out;
  } pix_out_t;

  typedef struct packed {
    logic signed [YIQ_W-1:0] y;
    logic signed [YIQ_W-1:0] i;
    logic signed [YIQ_W-1:0] q;
    logic                    last;
  } yiq_t;

  typedef struct packed {
    logic signed [ROT_W-1:0] y;
    logic signed [ROT_W-1:0] i;
    logic signed [ROT_W-1:0] q;
    logic                    last;
  } rot_t;

  typedef struct packed {
    logic en;
    logic valid;
  } stage_ctl_t;

endpackage

### sv/hue_rotate_yiq.sv
// Top level: YIQ hue rotation pipeline with angle registers.
//
//   channel | handshake             | payload
//   --------+-----------------------+---------------------------
//   in      | in_valid_i/in_ready_o | in_data_i  (pix_in_t)
//   out     | out_valid_o/out_ready_i | out_data_o (pix_out_t)
//   cfg     | cfg_we_i              | cfg_idx_i, cfg_wdata_i
//
// One pixel per cycle, unless the output stalls, through five register
// stages: YIQ matrix, rotation products, rotation sums, RGB products,
// sums and clamp.
// Reset clears all stage valid bits and loads cos 1.0, sin 0.
// A stalled output holds every stage; the pipeline advances whenever the
// output register is empty or being taken.
module hue_rotate_yiq import hry_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pix_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pix_out_t             out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ANGLE_W-1:0]   cfg_wdata_i
);

  logic signed [ANGLE_W-1:0] cos_q, sin_q;
  logic                      advance;
  logic                      yiq_valid, rot_valid, rgb_valid;
  yiq_t                      yiq;
  rot_t                      rot;
  stage_ctl_t                ctl_yiq, ctl_rot, ctl_rgb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q <= COS_RESET;
      sin_q <= SIN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_COS: cos_q <= signed'(cfg_wdata_i);
        CFG_SIN: sin_q <= signed'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  assign advance    = !rgb_valid || out_ready_i;
  assign in_ready_o = advance;

  assign ctl_yiq = '{en: advance, valid: in_valid_i};
  assign ctl_rot = '{en: advance, valid: yiq_valid};
  assign ctl_rgb = '{en: advance, valid: rot_valid};

  hry_to_yiq u_to_yiq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_yiq),
    .pix_i   (in_data_i),
    .valid_o (yiq_valid),
    .yiq_o   (yiq)
  );

  hry_rotate u_rotate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_rot),
    .yiq_i   (yiq),
    .cos_i   (cos_q),
    .sin_i   (sin_q),
    .valid_o (rot_valid),
    .rot_o   (rot)
  );

  hry_to_rgb u_to_rgb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_rgb),
    .rot_i   (rot),
    .valid_o (rgb_valid),
    .pix_o   (out_data_o)
  );

  assign out_valid_o = rgb_valid;

endmodule

### sv/hry_to_yiq.sv
// Stage one: RGB to YIQ constant matrix.
module hry_to_yiq import hry_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  stage_ctl_t ctl_i,
  input  pix_in_t    pix_i,
  output logic       valid_o,
  output yiq_t       yiq_o
);

  logic signed [YIQ_W-1:0] acc_d [3];
  logic                    valid_q;
  yiq_t                    yiq_q;

  always_comb begin
    logic signed [YIQ_W-1:0] ch [3];
    ch[0] = YIQ_W'(signed'({1'b0, pix_i.red_in}));
    ch[1] = YIQ_W'(signed'({1'b0, pix_i.green_in}));
    ch[2] = YIQ_W'(signed'({1'b0, pix_i.blue_in}));
    for (int r = 0; r < 3; r++) begin
      acc_d[r] = '0;
      for (int c = 0; c < 3; c++) begin
        acc_d[r] = acc_d[r] + YIQ_W'(TO_YIQ[r][c]) * ch[c];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.en) begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      yiq_q.y    <= acc_d[0];
      yiq_q.i    <= acc_d[1];
      yiq_q.q    <= acc_d[2];
      yiq_q.last <= pix_i.last_pixel;
    end
  end

  assign valid_o = valid_q;
  assign yiq_o   = yiq_q;

endmodule

### sv/hry_rotate.sv
// Stages two and three: I/Q rotation products, then sums with floor shift.
module hry_rotate import hry_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  stage_ctl_t                ctl_i,
  input  yiq_t                      yiq_i,
  input  logic signed [ANGLE_W-1:0] cos_i,
  input  logic signed [ANGLE_W-1:0] sin_i,
  output logic                      valid_o,
  output rot_t                      rot_o
);

  logic                     p_valid_q;
  logic signed [PROD_W-1:0] ci_q, sq_q, si_q, cq_q;
  logic signed [YIQ_W-1:0]  p_y_q;
  logic                     p_last_q;

  logic                     r_valid_q;
  rot_t                     rot_q;

  logic signed [PROD_W:0]   sum_i_d, sum_q_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      r_valid_q <= 1'b0;
    end else if (ctl_i.en) begin
      p_valid_q <= ctl_i.valid;
      r_valid_q <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      ci_q     <= PROD_W'(cos_i) * PROD_W'(yiq_i.i);
      sq_q     <= PROD_W'(sin_i) * PROD_W'(yiq_i.q);
      si_q     <= PROD_W'(sin_i) * PROD_W'(yiq_i.i);
      cq_q     <= PROD_W'(cos_i) * PROD_W'(yiq_i.q);
      p_y_q    <= yiq_i.y;
      p_last_q <= yiq_i.last;
    end
  end

  assign sum_i_d = (PROD_W+1)'(ci_q) - (PROD_W+1)'(sq_q);
  assign sum_q_d = (PROD_W+1)'(si_q) + (PROD_W+1)'(cq_q);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      rot_q.y    <= ROT_W'(p_y_q);
      rot_q.i    <= ROT_W'(sum_i_d >>> COEF_FRAC_BITS);
      rot_q.q    <= ROT_W'(sum_q_d >>> COEF_FRAC_BITS);
      rot_q.last <= p_last_q;
    end
  end

  assign valid_o = r_valid_q;
  assign rot_o   = rot_q;

endmodule

### sv/hry_to_rgb.sv
// Stages four and five: YIQ to RGB products, then row sums with clamp.
module hry_to_rgb import hry_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  stage_ctl_t ctl_i,
  input  rot_t       rot_i,
  output logic       valid_o,
  output pix_out_t   pix_o
);

  logic                    m_valid_q;
  logic signed [ACC_W-1:0] prod_q [3][3];
  logic                    m_last_q;

  logic                    o_valid_q;
  pix_out_t                pix_q;

  logic [CHANNEL_BITS-1:0] chan_d [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else if (ctl_i.en) begin
      m_valid_q <= ctl_i.valid;
      o_valid_q <= m_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      for (int r = 0; r < 3; r++) begin
        prod_q[r][0] <= ACC_W'(TO_RGB[r][0]) * ACC_W'(rot_i.y);
        prod_q[r][1] <= ACC_W'(TO_RGB[r][1]) * ACC_W'(rot_i.i);
        prod_q[r][2] <= ACC_W'(TO_RGB[r][2]) * ACC_W'(rot_i.q);
      end
      m_last_q <= rot_i.last;
    end
  end

  always_comb begin
    logic signed [ACC_W-1:0] acc;
    logic        [ACC_W-1:0] whole;
    for (int r = 0; r < 3; r++) begin
      acc   = prod_q[r][0] + prod_q[r][1] + prod_q[r][2];
      whole = ACC_W'($unsigned(acc) >> (2 * COEF_FRAC_BITS));
      if (acc[ACC_W-1]) begin
        chan_d[r] = '0;
      end else if (whole > ACC_W'(CHAN_MAX)) begin
        chan_d[r] = CHAN_MAX;
      end else begin
        chan_d[r] = whole[CHANNEL_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      pix_q.red_out   <= chan_d[0];
      pix_q.green_out <= chan_d[1];
      pix_q.blue_out  <= chan_d[2];
      pix_q.last_out  <= m_last_q;
    end
  end

  assign valid_o = o_valid_q;
  assign pix_o   = pix_q;

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench for hue_rotate_yiq: table-driven and random pixels checked against a fixed-point model.
module tb_top;
  import hry_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  localparam logic [ANGLE_W-1:0] ANG_ONE     = 16'h4000;
  localparam logic [ANGLE_W-1:0] ANG_NEG_ONE = 16'hC000;
  localparam logic [ANGLE_W-1:0] ANG_ZERO    = 16'h0000;
  localparam logic [ANGLE_W-1:0] ANG_MAX     = 16'h7FFF;
  localparam logic [ANGLE_W-1:0] ANG_MIN     = 16'h8000;
  localparam logic [ANGLE_W-1:0] ANG_PICKS [5] = '{ANG_ONE, ANG_NEG_ONE, ANG_ZERO, ANG_MAX, ANG_MIN};

  localparam int YIQ_MILLI [3][3] = '{'{299, 587, 114}, '{596, -274, -321}, '{211, -523, 311}};
  localparam int RGB_MILLI [3][3] = '{'{1000, 956, 621}, '{1000, -272, -647},
                                      '{1000, -1107, 1705}};

  localparam pix_out_t NO_CHECK = '0;
  localparam int DIR_ROWS = 22;
  localparam int SEG_ITEMS = 33;

  typedef struct packed {
    logic [ANGLE_W-1:0] cos_v;
    logic [ANGLE_W-1:0] sin_v;
    pix_in_t            pix;
    logic               known;
    pix_out_t           want;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{ANG_ONE,     ANG_ZERO, '{8'd0,   8'd0,   8'd0,   1'b0}, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b0}},
    '{ANG_ONE,     ANG_ZERO, '{8'd255, 8'd255, 8'd255, 1'b0}, 1'b0, NO_CHECK},
    '{ANG_ONE,     ANG_ZERO, '{8'd255, 8'd0,   8'd0,   1'b0}, 1'b0, NO_CHECK},
    '{ANG_ONE,     ANG_ZERO, '{8'd0,   8'd255, 8'd0,   1'b0}, 1'b0, NO_CHECK},
    '{ANG_ONE,     ANG_ZERO, '{8'd0,   8'd0,   8'd255, 1'b1}, 1'b0, NO_CHECK},
    '{ANG_ONE,     ANG_ZERO, '{8'd1,   8'd2,   8'd3,   1'b0}, 1'b0, NO_CHECK},
    '{ANG_ZERO,    ANG_ZERO, '{8'd0,   8'd0,   8'd0,   1'b0}, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b0}},
    '{ANG_ZERO,    ANG_ZERO, '{8'd128, 8'd128, 8'd128, 1'b0}, 1'b1,
      '{8'd128, 8'd128, 8'd128, 1'b0}},
    '{ANG_ZERO,    ANG_ZERO, '{8'd255, 8'd255, 8'd255, 1'b1}, 1'b1,
      '{8'd255, 8'd255, 8'd255, 1'b1}},
    '{ANG_ZERO,    ANG_ZERO, '{8'd255, 8'd0,   8'd0,   1'b0}, 1'b0, NO_CHECK},
    '{ANG_ZERO,    ANG_ONE,  '{8'd255, 8'd255, 8'd255, 1'b0}, 1'b0, NO_CHECK},
    '{ANG_ZERO,    ANG_ONE,  '{8'd255, 8'd0,   8'd0,   1'b0}, 1'b0, NO_CHECK},
    '{ANG_ZERO,    ANG_ONE,  '{8'd0,   8'd255, 8'd0,   1'b0}, 1'b0, NO_CHECK},
    '{ANG_ZERO,    ANG_ONE,  '{8'd0,   8'd0,   8'd255, 1'b0}, 1'b0, NO_CHECK},
    '{ANG_NEG_ONE, ANG_ZERO, '{8'd255, 8'd0,   8'd0,   1'b0}, 1'b0, NO_CHECK},
    '{ANG_NEG_ONE, ANG_ZERO, '{8'd0,   8'd255, 8'd255, 1'b1}, 1'b0, NO_CHECK},
    '{ANG_MAX,     ANG_MAX,  '{8'd255, 8'd0,   8'd0,   1'b0}, 1'b0, NO_CHECK},
    '{ANG_MAX,     ANG_MAX,  '{8'd0,   8'd0,   8'd255, 1'b0}, 1'b0, NO_CHECK},
    '{ANG_MAX,     ANG_MAX,  '{8'd0,   8'd0,   8'd0,   1'b1}, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b1}},
    '{ANG_MIN,     ANG_MIN,  '{8'd255, 8'd255, 8'd0,   1'b0}, 1'b0, NO_CHECK},
    '{ANG_MIN,     ANG_MIN,  '{8'd0,   8'd255, 8'd0,   1'b0}, 1'b0, NO_CHECK},
    '{ANG_MIN,     ANG_MIN,  '{8'd170, 8'd85,  8'd51,  1'b1}, 1'b0, NO_CHECK}
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  pix_in_t              in_data_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  pix_out_t             out_data_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [ANGLE_W-1:0]   cfg_wdata_i;

  pix_out_t                  expected_pix [$];
  pix_out_t                  pix_head;
  logic signed [ANGLE_W-1:0] cos_q;
  logic signed [ANGLE_W-1:0] sin_q;
  int                        send_idle_pct;
  int                        recv_stall_pct;
  int                        n_errors;
  int                        n_checked;
  int                        n_settings;

  hue_rotate_yiq uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint milli_to_q(input int k);
    longint mag;
    mag = (k < 0) ? -longint'(k) : longint'(k);
    mag = (mag * (longint'(1) << COEF_FRAC_BITS) + 500) / 1000;
    return (k < 0) ? -mag : mag;
  endfunction

  function automatic pix_out_t hue_rotate(input pix_in_t p, input logic signed [ANGLE_W-1:0] cs,
                                          input logic signed [ANGLE_W-1:0] sn);
    longint   rgb [3];
    longint   yiq [3];
    longint   rot [3];
    longint   ch [3];
    longint   acc;
    longint   c_l;
    longint   s_l;
    longint   top;
    pix_out_t o;
    c_l = longint'(cs);
    s_l = longint'(sn);
    top = (longint'(1) << CHANNEL_BITS) - 1;
    rgb[0] = longint'(p.red_in);
    rgb[1] = longint'(p.green_in);
    rgb[2] = longint'(p.blue_in);
    for (int r = 0; r < 3; r++) begin
      acc = 0;
      for (int c = 0; c < 3; c++) acc += milli_to_q(YIQ_MILLI[r][c]) * rgb[c];
      yiq[r] = acc;
    end
    rot[0] = yiq[0];
    rot[1] = (c_l * yiq[1] - s_l * yiq[2]) >>> COEF_FRAC_BITS;
    rot[2] = (s_l * yiq[1] + c_l * yiq[2]) >>> COEF_FRAC_BITS;
    for (int r = 0; r < 3; r++) begin
      acc = 0;
      for (int c = 0; c < 3; c++) acc += milli_to_q(RGB_MILLI[r][c]) * rot[c];
      if (acc < 0) begin
        ch[r] = 0;
      end else begin
        ch[r] = acc >>> (2 * COEF_FRAC_BITS);
        if (ch[r] > top) ch[r] = top;
      end
    end
    o.red_out   = CHANNEL_BITS'(ch[0]);
    o.green_out = CHANNEL_BITS'(ch[1]);
    o.blue_out  = CHANNEL_BITS'(ch[2]);
    o.last_out  = p.last_pixel;
    return o;
  endfunction

  function automatic logic [ANGLE_W-1:0] pick_angle();
    logic [ANGLE_W-1:0] v;
    case ($urandom_range(3))
      0: v = ANG_PICKS[3'($urandom_range(4))];
      1, 2: v = ANGLE_W'($urandom_range(32768)) - ANG_ONE;
      default: v = ANGLE_W'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [CHANNEL_BITS-1:0] rand_chan();
    logic [CHANNEL_BITS-1:0] v;
    case ($urandom_range(7))
      0: v = '0;
      1: v = CHAN_MAX;
      default: v = CHANNEL_BITS'($urandom);
    endcase
    return v;
  endfunction

  function automatic pix_in_t rand_pixel();
    pix_in_t p;
    p.red_in     = rand_chan();
    p.green_in   = rand_chan();
    p.blue_in    = rand_chan();
    p.last_pixel = ($urandom_range(7) == 0);
    return p;
  endfunction

  task automatic send_pixel(input pix_in_t p, input logic known, input pix_out_t want);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= p;
    do @(posedge clk_i); while (!in_ready_o);
    expected_pix.push_back(known ? want : hue_rotate(p, cos_q, sin_q));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_pix.size() != 0) @(posedge clk_i);
  endtask

  // spare indexes get random data and must be ignored
  task automatic load_angle(input logic [ANGLE_W-1:0] c, input logic [ANGLE_W-1:0] s);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_COS;
    cfg_wdata_i <= c;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_SIN;
    cfg_wdata_i <= s;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_SPARE_A;
    cfg_wdata_i <= ANGLE_W'($urandom);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_SPARE_B;
    cfg_wdata_i <= ANGLE_W'($urandom);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cos_q = c;
    sin_q = s;
    n_settings++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_pix.size() == 0) begin
        $error("pixel with nothing pending: %h", out_data_o);
        n_errors++;
      end else begin
        pix_head = expected_pix.pop_front();
        n_checked++;
        if (out_data_o.red_out !== pix_head.red_out) begin
          $error("red_out: expected %0d, got %0d", pix_head.red_out, out_data_o.red_out);
          n_errors++;
        end
        if (out_data_o.green_out !== pix_head.green_out) begin
          $error("green_out: expected %0d, got %0d", pix_head.green_out, out_data_o.green_out);
          n_errors++;
        end
        if (out_data_o.blue_out !== pix_head.blue_out) begin
          $error("blue_out: expected %0d, got %0d", pix_head.blue_out, out_data_o.blue_out);
          n_errors++;
        end
        if (out_data_o.last_out !== pix_head.last_out) begin
          $error("last_out: expected %0d, got %0d", pix_head.last_out, out_data_o.last_out);
          n_errors++;
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    out_ready_i    = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_COS;
    cfg_wdata_i    = '0;
    cos_q          = COS_RESET;
    sin_q          = SIN_RESET;
    n_errors       = 0;
    n_checked      = 0;
    n_settings     = 0;
    send_idle_pct  = 10;
    recv_stall_pct = 70;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int k = 0; k < DIR_ROWS; k++) begin
      if (DIR_TAB[k].cos_v != cos_q || DIR_TAB[k].sin_v != sin_q) begin
        drain();
        load_angle(DIR_TAB[k].cos_v, DIR_TAB[k].sin_v);
      end
      send_pixel(DIR_TAB[k].pix, DIR_TAB[k].known, DIR_TAB[k].want);
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct  = (ph == 0) ? 10 : (ph == 1) ? 70 : 0;
      recv_stall_pct = (ph == 0) ? 70 : (ph == 1) ? 10 : 0;
      for (int seg = 0; seg < 5; seg++) begin
        drain();
        load_angle(pick_angle(), pick_angle());
        repeat (SEG_ITEMS) send_pixel(rand_pixel(), 1'b0, NO_CHECK);
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    $display("Checked %0d pixels across %0d angle settings, including register extremes,",
             n_checked, n_settings + 1);
    $display("writes to unused indexes, and both sender-heavy and receiver-heavy stalls.");
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
